/* hdl/ippra_pkg.sv */
// shared types, codes and constants of the ipp request attribute parser
package ippra_pkg;

    // one input transfer: a byte of the request body
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    // one result transfer
    typedef struct packed {
        logic [2:0]         kind;
        logic               attribute;
        logic [15:0]        value;
        logic signed [31:0] job_id;
        logic [7:0]         version_major;
        logic [7:0]         version_minor;
        logic [15:0]        operation_id;
        logic [31:0]        request_id;
    } t_out_item;

    // result kinds
    localparam logic [2:0] KIND_HEADER      = 3'd0;
    localparam logic [2:0] KIND_VALUE_START = 3'd1;
    localparam logic [2:0] KIND_VALUE_BYTE  = 3'd2;
    localparam logic [2:0] KIND_JOB_ID      = 3'd3;
    localparam logic [2:0] KIND_DONE        = 3'd4;
    localparam logic [2:0] KIND_TRUNCATED   = 3'd5;

    // attribute codes
    localparam logic [1:0] ATTR_FORMAT   = 2'd0;
    localparam logic [1:0] ATTR_JOB_NAME = 2'd1;
    localparam logic [1:0] ATTR_JOB_ID   = 2'd2;
    localparam logic [1:0] ATTR_NONE     = 2'd3;

    // value capture modes
    localparam logic [1:0] CAP_SKIP   = 2'd0;
    localparam logic [1:0] CAP_STRING = 2'd1;
    localparam logic [1:0] CAP_JOB    = 2'd2;

    // parse phases
    typedef enum logic [8:0] {
        PH_HEADER  = 9'b000000001,
        PH_TAG     = 9'b000000010,
        PH_NLEN_HI = 9'b000000100,
        PH_NLEN_LO = 9'b000001000,
        PH_NAME    = 9'b000010000,
        PH_VLEN_HI = 9'b000100000,
        PH_VLEN_LO = 9'b001000000,
        PH_VALUE   = 9'b010000000,
        PH_ENDED   = 9'b100000000
    } t_phase;

    // name compare state
    typedef struct packed {
        logic [5:0] pos;
        logic [2:0] flags;
        logic       term;
    } t_name_state;

    localparam logic [16:0] FORMAT_CAPACITY   = 17'd64;
    localparam logic [16:0] JOB_NAME_CAPACITY = 17'd64;
    localparam logic [5:0]  NAME_KEEP         = 6'd47;
    localparam logic [5:0]  HEADER_LEN        = 6'd8;
    localparam logic [7:0]  DELIM_MAX         = 8'h0F;
    localparam logic [15:0] JOB_ID_LEN        = 16'd4;
    localparam logic [7:0]  END_TAG_RESET     = 8'd3;

    // target names and their lengths
    localparam logic [8*15-1:0] NAME_FORMAT   = "document-format";
    localparam logic [8*8-1:0]  NAME_JOB_NAME = "job-name";
    localparam logic [8*6-1:0]  NAME_JOB_ID   = "job-id";
    localparam logic [5:0]      LEN_FORMAT    = 6'd15;
    localparam logic [5:0]      LEN_JOB_NAME  = 6'd8;
    localparam logic [5:0]      LEN_JOB_ID    = 6'd6;

    // length of a target name
    function automatic logic [5:0] name_len(input logic [1:0] t);
        logic [5:0] l;
        case (t)
            ATTR_FORMAT:   l = LEN_FORMAT;
            ATTR_JOB_NAME: l = LEN_JOB_NAME;
            ATTR_JOB_ID:   l = LEN_JOB_ID;
            default:       l = 6'd0;
        endcase
        return l;
    endfunction

    // character of a target name at a position, zero past its end
    function automatic logic [7:0] name_char(input logic [1:0] t, input logic [5:0] pos);
        logic [7:0] ch;
        ch = 8'd0;
        case (t)
            ATTR_FORMAT: begin
                if (pos < LEN_FORMAT) ch = NAME_FORMAT[8*(14 - int'(pos)) +: 8];
            end
            ATTR_JOB_NAME: begin
                if (pos < LEN_JOB_NAME) ch = NAME_JOB_NAME[8*(7 - int'(pos)) +: 8];
            end
            ATTR_JOB_ID: begin
                if (pos < LEN_JOB_ID) ch = NAME_JOB_ID[8*(5 - int'(pos)) +: 8];
            end
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

/* hdl/ippra_name_match.sv */
// per-byte attribute name compare against the three target names
module ippra_name_match (
    input  ippra_pkg::t_name_state i_name,
    input  logic [7:0]             i_byte,
    output ippra_pkg::t_name_state o_name,
    output logic [1:0]             o_attr
);
    import ippra_pkg::*;

    // flag update for one name byte
    always_comb begin
        o_name = i_name;
        if (!i_name.term && (i_name.pos < NAME_KEEP)) begin
            if (i_byte == 8'd0) begin
                o_name.term = 1'b1;
            end else begin
                for (int t = 0; t < 3; t++) begin
                    if (i_name.flags[t] &&
                        ((i_name.pos >= name_len(2'(t))) ||
                         (name_char(2'(t), i_name.pos) != i_byte))) begin
                        o_name.flags[t] = 1'b0;
                    end
                end
                o_name.pos = i_name.pos + 6'd1;
            end
        end
    end

    // attribute chosen if the name ended here
    always_comb begin
        o_attr = ATTR_NONE;
        for (int t = 0; t < 3; t++) begin
            if (o_name.flags[t] && (name_len(2'(t)) == o_name.pos)) o_attr = 2'(t);
        end
    end

endmodule

/* hdl/ippra_core.sv */
// parse state registers and the per-byte step logic
module ippra_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  ippra_pkg::t_in_item  i_item,
    input  logic [7:0]           i_end_tag,
    output logic                 o_res_valid,
    output ippra_pkg::t_out_item o_res
);
    import ippra_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_len_hi, n_len_hi;
    t_name_state r_name, n_name;
    logic [1:0]  r_attr, n_attr;
    logic [1:0]  r_cap, n_cap;
    logic [7:0]  r_major, n_major;
    logic [7:0]  r_minor, n_minor;
    logic [15:0] r_op, n_op;
    logic [31:0] r_req, n_req;
    logic [31:0] r_job, n_job;

    t_name_state match_name;
    logic [1:0]  match_attr;
    logic [7:0]  b;
    logic [15:0] len;
    logic        have;
    t_out_item   res;

    assign b   = i_item.data_byte;
    assign len = {r_len_hi, b};

    ippra_name_match u_name_match (
        .i_name (r_name),
        .i_byte (b),
        .o_name (match_name),
        .o_attr (match_attr)
    );

    // next state and result for one byte
    always_comb begin
        n_phase  = r_phase;
        n_rem    = r_rem;
        n_len_hi = r_len_hi;
        n_name   = r_name;
        n_attr   = r_attr;
        n_cap    = r_cap;
        n_major  = r_major;
        n_minor  = r_minor;
        n_op     = r_op;
        n_req    = r_req;
        n_job    = r_job;
        have     = 1'b0;
        res      = '0;
        case (r_phase)
            PH_HEADER: begin
                if (r_name.pos == 6'd0) begin
                    n_major = b;
                end else if (r_name.pos == 6'd1) begin
                    n_minor = b;
                end else if (r_name.pos <= 6'd3) begin
                    n_op = {r_op[7:0], b};
                end else begin
                    n_req = {r_req[23:0], b};
                end
                n_name.pos = r_name.pos + 6'd1;
                if (n_name.pos >= HEADER_LEN) begin
                    n_name.pos        = 6'd0;
                    res.kind          = KIND_HEADER;
                    res.version_major = n_major;
                    res.version_minor = n_minor;
                    res.operation_id  = n_op;
                    res.request_id    = n_req;
                    have              = 1'b1;
                    n_phase           = PH_TAG;
                end
            end
            PH_TAG: begin
                if (b == i_end_tag) begin
                    res.kind = KIND_DONE;
                    have     = 1'b1;
                    n_phase  = PH_ENDED;
                end else if (b > DELIM_MAX) begin
                    n_phase = PH_NLEN_HI;
                end
            end
            PH_NLEN_HI: begin
                n_len_hi = b;
                n_phase  = PH_NLEN_LO;
            end
            PH_VLEN_HI: begin
                n_len_hi = b;
                n_phase  = PH_VLEN_LO;
            end
            PH_NLEN_LO: begin
                if (len == 16'd0) begin
                    n_phase = PH_VLEN_HI;
                end else begin
                    n_rem   = len;
                    n_name  = '{pos: 6'd0, flags: 3'b111, term: 1'b0};
                    n_phase = PH_NAME;
                end
            end
            PH_NAME: begin
                n_name = match_name;
                n_rem  = r_rem - 16'd1;
                if (n_rem == 16'd0) begin
                    n_attr  = match_attr;
                    n_phase = PH_VLEN_HI;
                end
            end
            PH_VLEN_LO: begin
                if (((r_attr == ATTR_FORMAT) && ({1'b0, len} < FORMAT_CAPACITY)) ||
                    ((r_attr == ATTR_JOB_NAME) && ({1'b0, len} < JOB_NAME_CAPACITY))) begin
                    res.kind      = KIND_VALUE_START;
                    res.attribute = r_attr[0];
                    res.value     = len;
                    have          = 1'b1;
                    n_cap         = CAP_STRING;
                end else if ((r_attr == ATTR_JOB_ID) && (len == JOB_ID_LEN)) begin
                    n_cap = CAP_JOB;
                    n_job = 32'd0;
                end else begin
                    n_cap = CAP_SKIP;
                end
                n_rem   = len;
                n_phase = (len == 16'd0) ? PH_TAG : PH_VALUE;
            end
            PH_VALUE: begin
                n_rem = r_rem - 16'd1;
                if (r_cap == CAP_STRING) begin
                    res.kind      = KIND_VALUE_BYTE;
                    res.attribute = r_attr[0];
                    res.value     = {8'd0, b};
                    have          = 1'b1;
                end else if (r_cap == CAP_JOB) begin
                    n_job = {r_job[23:0], b};
                    if (n_rem == 16'd0) begin
                        res.kind   = KIND_JOB_ID;
                        res.job_id = n_job;
                        have       = 1'b1;
                    end
                end
                if (n_rem == 16'd0) begin
                    n_cap   = CAP_SKIP;
                    n_phase = PH_TAG;
                end
            end
            default: begin
                n_phase = PH_ENDED;
            end
        endcase

        // final byte of a body: done, silent or truncated, then start over
        if (i_item.last) begin
            if (r_phase == PH_ENDED) begin
                have = 1'b0;
            end else if (!(have && (res.kind == KIND_DONE))) begin
                res      = '0;
                res.kind = KIND_TRUNCATED;
                have     = 1'b1;
            end
            n_phase  = PH_HEADER;
            n_rem    = 16'd0;
            n_len_hi = 8'd0;
            n_name   = '0;
            n_attr   = ATTR_NONE;
            n_cap    = CAP_SKIP;
            n_major  = 8'd0;
            n_minor  = 8'd0;
            n_op     = 16'd0;
            n_req    = 32'd0;
            n_job    = 32'd0;
        end
    end

    assign o_res_valid = have;
    assign o_res       = res;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_rem    <= 16'd0;
            r_len_hi <= 8'd0;
            r_name   <= '0;
            r_attr   <= ATTR_NONE;
            r_cap    <= CAP_SKIP;
            r_major  <= 8'd0;
            r_minor  <= 8'd0;
            r_op     <= 16'd0;
            r_req    <= 32'd0;
            r_job    <= 32'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_rem    <= n_rem;
            r_len_hi <= n_len_hi;
            r_name   <= n_name;
            r_attr   <= n_attr;
            r_cap    <= n_cap;
            r_major  <= n_major;
            r_minor  <= n_minor;
            r_op     <= n_op;
            r_req    <= n_req;
            r_job    <= n_job;
        end
    end

endmodule

/* hdl/ipp_request_attribute_parser.sv */
// top level of the ipp request attribute parser
//
//  channel   direction  valid / flow      payload
//  in        input      i_in_valid  / o_in_stall    i_in_data  (one body byte, last flag)
//  out       output     o_out_valid / i_out_stall   o_out_data (zero or one result per byte)
//  cfg       input      i_cfg_we                    i_cfg_data (end tag)
//
// one byte per cycle sustained while the output is not stalled; each result is registered
// bytes pass an input register, one step of the parse state, then the result register
// reset is synchronous, active low; end tag returns to 3 and the parser to the header
// a stalled result holds the step; the input register still takes one more byte if it is empty
module ipp_request_attribute_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ippra_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ippra_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data
);
    import ippra_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic [7:0] r_end_tag;

    logic      step;
    logic      res_valid;
    t_out_item res;

    // step when a byte waits and the result register is free or draining
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;

    ippra_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_end_tag   (r_end_tag),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // end tag register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_tag <= END_TAG_RESET;
        end else if (i_cfg_we) begin
            r_end_tag <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
